// ----- hdl/quoted_token_splitter_top_assert.svh -----
// assertion macros shared by the splitter modules
`ifndef QUOTED_TOKEN_SPLITTER_TOP_ASSERT_SVH
`define QUOTED_TOKEN_SPLITTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked on every rising clock edge outside reset
`define QTS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// at most one bit of the vector set
`define QTS_ASSERT_ONEHOT0(lbl, clk, rst_n, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(sig)) else $error(msg);
`else
`define QTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define QTS_ASSERT_ONEHOT0(lbl, clk, rst_n, sig, msg)
`endif

`endif

// ----- hdl/qts_pkg.sv -----
package qts_pkg;

	// scanner modes
	typedef enum logic [2:0] {
		MODE_BETWEEN = 3'd0,
		MODE_PLAIN   = 3'd1,
		MODE_DQ      = 3'd2,
		MODE_DQ_ESC  = 3'd3,
		MODE_SQ      = 3'd4,
		MODE_SQ_ESC  = 3'd5
	} mode_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_EOL_OK  = 2'd1,
		KIND_EOL_ERR = 2'd2
	} kind_t;

	// token types
	typedef enum logic [1:0] {
		TYPE_PLAIN = 2'd0,
		TYPE_DQ    = 2'd1,
		TYPE_SQ    = 2'd2
	} tok_type_t;

	// one result
	typedef struct packed {
		kind_t     kind;
		logic [7:0] tok_byte;
		logic      first;
		logic      last;
		tok_type_t ttype;
	} res_t;

	// number of result slots one item can fill: held byte, new byte, line-end marker
	localparam int unsigned SLOTS = 3;
	localparam int unsigned SLOT_HELD = 0;
	localparam int unsigned SLOT_NEW = 1;
	localparam int unsigned SLOT_EOL = 2;

	// queue entry: all results caused by one item
	typedef struct packed {
		logic [SLOTS-1:0] valid;
		res_t [SLOTS-1:0] res;
	} entry_t;

	// depth of the queue between front and back
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

endpackage

// ----- hdl/quoted_token_splitter_top.sv -----
// Quoted token splitter: takes one byte of a text line per item and gives
// the bytes of its tokens, split at space, tab, CR and LF. A token opening
// with a double quote runs to the closing quote, a backslash inside hiding
// the next byte; one opening with a single quote treats every backslash as an
// escape of the next byte; bytes after a closing quote
// stay in the token up to the next whitespace. Each token byte comes out
// one item late, since one byte is held back so the final byte can be
// marked. A line-end item gives a marker after the token bytes: kind 1 when
// all is closed, kind 2 when a quote or a backslash is still open, and then
// the partial token must be dropped downstream. An input item with neither a
// byte nor a line end gives no result. m_tlast marks the final result of the
// item that caused it. Rate: the front scanner accepts one item every cycle
// while the queue has room and writes all of its results as one entry into a
// four-entry queue; the back end gives one result per cycle through its output
// register while m_tready is high or the register is empty; an item gives zero
// to three results (one in the usual case of a mid-token byte), and s_tready
// falls only when the queue is full.
module quoted_token_splitter_top (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic [0:0]  s_tuser,   // [0] byte_present
	input  logic        s_tlast,   // line_end
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] token_byte, [8] first_of_token, [9] last_of_token
	output logic [3:0]  m_tuser,   // [1:0] result_kind, [3:2] token_type
	output logic        m_tlast    // last_of_run
);

	logic            accept;
	logic            push, full, pop, empty;
	qts_pkg::entry_t push_data, head;

	// the scanner advances on every accepted item
	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	// front: mode tracking and result slots per item
	qts_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.char_code    (s_tdata),
		.byte_present (s_tuser[0]),
		.line_end     (s_tlast),
		.push         (push),
		.push_data    (push_data)
	);

	// queue of result entries, one per item that causes any result
	qts_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	// back: walks the slots of the head entry, one result per cycle while the output register is free
	qts_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- hdl/qts_front.sv -----
module qts_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       char_code,
	input  logic             byte_present,
	input  logic             line_end,
	output logic             push,
	output qts_pkg::entry_t  push_data
);

	`include "quoted_token_splitter_top_assert.svh"

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;

	qts_pkg::mode_t     mode_q, mode_a, mode_d;
	logic [7:0]         held_byte_q, hb_a, hb_d;
	logic               held_valid_q, hv_a, hv_d;
	logic               held_first_q, hf_a, hf_d;
	qts_pkg::tok_type_t type_q, type_a, type_d;
	logic               sp;

	assign sp = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
		(char_code == CH_LF) || (char_code == CH_CR);

	// next state: byte step, then line-end step
	always_comb begin
		mode_a = mode_q;
		hb_a   = held_byte_q;
		hv_a   = held_valid_q;
		hf_a   = held_first_q;
		type_a = type_q;
		if (byte_present) begin
			case (mode_q)
				qts_pkg::MODE_BETWEEN: begin
					if (!sp) begin
						hb_a = char_code;
						hv_a = 1'b1;
						hf_a = 1'b1;
						if (char_code == CH_DQ) begin
							type_a = qts_pkg::TYPE_DQ;
							mode_a = qts_pkg::MODE_DQ;
						end else if (char_code == CH_SQ) begin
							type_a = qts_pkg::TYPE_SQ;
							mode_a = qts_pkg::MODE_SQ;
						end else begin
							type_a = qts_pkg::TYPE_PLAIN;
							mode_a = qts_pkg::MODE_PLAIN;
						end
					end
				end
				qts_pkg::MODE_PLAIN: begin
					if (sp) begin
						hv_a   = 1'b0;
						mode_a = qts_pkg::MODE_BETWEEN;
					end else begin
						hb_a = char_code;
						hv_a = 1'b1;
						hf_a = 1'b0;
					end
				end
				qts_pkg::MODE_DQ: begin
					hb_a = char_code;
					hv_a = 1'b1;
					hf_a = 1'b0;
					if (char_code == CH_BSL) begin
						mode_a = qts_pkg::MODE_DQ_ESC;
					end else if (char_code == CH_DQ) begin
						mode_a = qts_pkg::MODE_PLAIN;
					end
				end
				qts_pkg::MODE_DQ_ESC: begin
					hb_a   = char_code;
					hv_a   = 1'b1;
					hf_a   = 1'b0;
					mode_a = qts_pkg::MODE_DQ;
				end
				qts_pkg::MODE_SQ: begin
					hb_a = char_code;
					hv_a = 1'b1;
					hf_a = 1'b0;
					if (char_code == CH_BSL) begin
						mode_a = qts_pkg::MODE_SQ_ESC;
					end else if (char_code == CH_SQ) begin
						mode_a = qts_pkg::MODE_PLAIN;
					end
				end
				qts_pkg::MODE_SQ_ESC: begin
					hb_a = char_code;
					hv_a = 1'b1;
					hf_a = 1'b0;
					// any other byte is hidden, another backslash escapes again
					mode_a = (char_code == CH_BSL) ? qts_pkg::MODE_SQ_ESC : qts_pkg::MODE_SQ;
				end
				default: begin
					mode_a = qts_pkg::MODE_BETWEEN;
				end
			endcase
		end
		mode_d = mode_a;
		hb_d   = hb_a;
		hv_d   = hv_a;
		hf_d   = hf_a;
		type_d = type_a;
		if (line_end) begin
			mode_d = qts_pkg::MODE_BETWEEN;
			hv_d   = 1'b0;
			hf_d   = 1'b0;
			type_d = qts_pkg::TYPE_PLAIN;
		end
	end

	// outputs: results this item causes
	always_comb begin
		push_data = '0;
		// old held byte leaves when a new byte joins the token or whitespace closes it
		push_data.valid[qts_pkg::SLOT_HELD] = byte_present && held_valid_q &&
			(mode_q != qts_pkg::MODE_BETWEEN);
		push_data.res[qts_pkg::SLOT_HELD].kind     = qts_pkg::KIND_BYTE;
		push_data.res[qts_pkg::SLOT_HELD].tok_byte = held_byte_q;
		push_data.res[qts_pkg::SLOT_HELD].first    = held_first_q;
		push_data.res[qts_pkg::SLOT_HELD].last     = (mode_q == qts_pkg::MODE_PLAIN) && sp;
		push_data.res[qts_pkg::SLOT_HELD].ttype    = type_q;
		// line end inside a token with no open quote closes the token
		push_data.valid[qts_pkg::SLOT_NEW] = line_end && hv_a &&
			(mode_a == qts_pkg::MODE_PLAIN);
		push_data.res[qts_pkg::SLOT_NEW].kind     = qts_pkg::KIND_BYTE;
		push_data.res[qts_pkg::SLOT_NEW].tok_byte = hb_a;
		push_data.res[qts_pkg::SLOT_NEW].first    = hf_a;
		push_data.res[qts_pkg::SLOT_NEW].last     = 1'b1;
		push_data.res[qts_pkg::SLOT_NEW].ttype    = type_a;
		// line-end marker
		push_data.valid[qts_pkg::SLOT_EOL] = line_end;
		if ((mode_a == qts_pkg::MODE_BETWEEN) || (mode_a == qts_pkg::MODE_PLAIN)) begin
			push_data.res[qts_pkg::SLOT_EOL].kind = qts_pkg::KIND_EOL_OK;
		end else begin
			push_data.res[qts_pkg::SLOT_EOL].kind = qts_pkg::KIND_EOL_ERR;
		end
		push = accept && (push_data.valid != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= qts_pkg::MODE_BETWEEN;
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
			held_first_q <= 1'b0;
			type_q       <= qts_pkg::TYPE_PLAIN;
		end else if (accept) begin
			mode_q       <= mode_d;
			held_byte_q  <= hb_d;
			held_valid_q <= hv_d;
			held_first_q <= hf_d;
			type_q       <= type_d;
		end
	end

	// a byte is held exactly while a token is open
	`QTS_ASSERT(a_held_matches_mode, clk, arst_n, held_valid_q == (mode_q != qts_pkg::MODE_BETWEEN), "held byte out of step with scan mode")
	// quote error only comes with an open quote
	`QTS_ASSERT(a_err_needs_quote, clk, arst_n, !(push && push_data.valid[qts_pkg::SLOT_EOL] && push_data.res[qts_pkg::SLOT_EOL].kind == qts_pkg::KIND_EOL_ERR && push_data.valid[qts_pkg::SLOT_NEW]), "error marker with closed token")

endmodule

// ----- hdl/qts_fifo.sv -----
module qts_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  qts_pkg::entry_t push_data,
	output logic            full,
	input  logic            pop,
	output qts_pkg::entry_t head,
	output logic            empty
);

	`include "quoted_token_splitter_top_assert.svh"

	qts_pkg::entry_t                    mem_q [qts_pkg::FIFO_DEPTH];
	logic [qts_pkg::PTR_W-1:0]          wr_ptr_q, rd_ptr_q;
	logic [qts_pkg::CNT_W-1:0]          count_q;

	assign full  = (count_q == qts_pkg::CNT_W'(qts_pkg::FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == qts_pkg::PTR_W'(qts_pkg::FIFO_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == qts_pkg::PTR_W'(qts_pkg::FIFO_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`QTS_ASSERT(a_no_overflow, clk, arst_n, !(push && full && !pop), "push into full queue")
	`QTS_ASSERT(a_no_underflow, clk, arst_n, !(pop && empty), "pop from empty queue")

endmodule

// ----- hdl/qts_back.sv -----
module qts_back (
	input  logic            clk,
	input  logic            arst_n,
	input  qts_pkg::entry_t head,
	input  logic            empty,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [15:0]     m_tdata,
	output logic [3:0]      m_tuser,
	output logic            m_tlast
);

	`include "quoted_token_splitter_top_assert.svh"

	logic [qts_pkg::SLOTS-1:0] done_q, pending, pick, rest;
	logic                      load;
	qts_pkg::res_t             sel;
	logic                      valid_q;
	qts_pkg::res_t             res_q;
	logic                      run_last_q;

	assign pending = empty ? '0 : (head.valid & ~done_q);
	assign pick    = pending & (~pending + 1'b1);
	assign rest    = pending & ~pick;
	assign load    = (pending != '0) && (!valid_q || m_tready);
	assign pop     = load && (rest == '0);

	always_comb begin
		case (pick)
			3'b001:  sel = head.res[qts_pkg::SLOT_HELD];
			3'b010:  sel = head.res[qts_pkg::SLOT_NEW];
			3'b100:  sel = head.res[qts_pkg::SLOT_EOL];
			default: sel = head.res[qts_pkg::SLOT_EOL];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				done_q <= (rest == '0) ? '0 : (done_q | pick);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q      <= sel;
			run_last_q <= (rest == '0);
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {6'b0, res_q.last, res_q.first, res_q.tok_byte};
	assign m_tuser  = {res_q.ttype, res_q.kind};
	assign m_tlast  = run_last_q;

	`QTS_ASSERT_ONEHOT0(a_pick_onehot, clk, arst_n, pick, "more than one slot picked")
	`QTS_ASSERT(a_done_subset, clk, arst_n, empty ? (done_q == '0) : ((done_q & ~head.valid) == '0), "emitted mask outside entry")

endmodule
